>>> rtl/plrt_pkg.sv
// plrt_pkg: shared constants and payload types for the peer liveness rank table
// no dependencies; imported by the interfaces, the table ram user and the core
`default_nettype none

package plrt_pkg;

  // table geometry
  localparam int unsigned NUM_PEERS = 255;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned ADDR_W    = $clog2(NUM_PEERS);
  localparam int unsigned ENTRY_W   = 2 * TIME_BITS;

  // field widths fixed by the interface
  localparam int unsigned PEER_W    = 8;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned PING_W    = 16;
  localparam int unsigned WINDOW_W  = PING_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_PERIOD  = 1'd1;

  // register reset values
  localparam logic [PEER_W-1:0]  OWN_ADDRESS_RST = 8'd0;
  localparam logic [PING_W-1:0]  PING_PERIOD_RST = 16'd10000;
  localparam logic [COUNT_W-1:0] RANK_RST        = 8'hff;
  localparam logic [COUNT_W-1:0] ALIVE_RST       = 8'd1;

  // request payload
  typedef struct packed {
    logic [PEER_W-1:0]    peer_address;
    logic [TIME_BITS-1:0] peer_clock;
    logic [TIME_BITS-1:0] local_time;
  } plrt_req_t;

  // response payload
  typedef struct packed {
    logic [COUNT_W-1:0] own_rank;
    logic [COUNT_W-1:0] alive_count;
    logic               status_changed;
  } plrt_rsp_t;

endpackage

`default_nettype wire

>>> rtl/plrt_if.sv
// plrt_if: valid/ready channel interfaces for requests and responses
// depends on plrt_pkg for the payload structs
`default_nettype none

interface plrt_req_if import plrt_pkg::*; ();
  logic      valid;
  logic      ready;
  plrt_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plrt_rsp_if import plrt_pkg::*; ();
  logic      valid;
  logic      ready;
  plrt_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/plrt_ram.sv
// plrt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module plrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/peer_liveness_rank_table_core.sv
// peer_liveness_rank_table_core: peer table with expiry sweep, alive count and rank
// depends on plrt_pkg, plrt_if (plrt_req_if, plrt_rsp_if) and plrt_ram
//
//   channel   dir   handshake              payload
//   req_i     in    valid/ready            peer_address, peer_clock, local_time
//   rsp_o     out   valid/ready            own_rank, alive_count, status_changed
//   cfg       in    cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// one request at a time: the accept cycle writes the entry, then the sweep reads one
// table entry per cycle from the ram (NUM_PEERS reads), the last entry is evaluated
// after the last read, and then the response register is loaded.
// a new request is taken once the response register has room for the previous result.
// entry presence lives in per-entry valid flops cleared by reset, so no clearing pass.
// a stalled response only holds the result register; the next sweep waits at its end.
`default_nettype none

module peer_liveness_rank_table_core
  import plrt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  plrt_req_if.sink                   req_i,
  plrt_rsp_if.source                 rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_PEERS - 1);

  logic [1:0]           state_q, state_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic                 eval_en_q;
  logic                 eval_vld_q;
  logic [ADDR_W-1:0]    eval_idx_q;
  logic [TIME_BITS-1:0] now_q;
  logic [COUNT_W-1:0]   alive_cnt_q, rank_cnt_q;
  logic [COUNT_W-1:0]   cur_rank_q, cur_alive_q;
  logic [PEER_W-1:0]    own_addr_q;
  logic [PING_W-1:0]    ping_q;
  logic [NUM_PEERS-1:0] valid_q;
  logic                 rsp_valid_q;
  plrt_rsp_t            rsp_q;

  logic                 req_fire;
  logic                 addr_ok;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_data;
  logic [TIME_BITS-1:0] ent_clock, ent_seen;
  logic [WINDOW_W-1:0]  window;
  logic [TIME_BITS:0]   expiry;
  logic                 live, rank_hit, expire;
  logic                 rsp_load;

  // request handshake and write address check
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign addr_ok     = (req_i.data.peer_address < PEER_W'(NUM_PEERS));
  assign wr_addr     = req_i.data.peer_address[ADDR_W-1:0];
  assign rd_en       = (state_q == ST_SWEEP);

  plrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PEERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (req_fire && addr_ok),
    .waddr_i (wr_addr),
    .wdata_i ({req_i.data.peer_clock, req_i.data.local_time}),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // entry evaluation, in the cycle after the read
  assign ent_clock = rd_data[ENTRY_W-1:TIME_BITS];
  assign ent_seen  = rd_data[TIME_BITS-1:0];
  assign window    = {ping_q, 1'b0};
  assign expiry    = {1'b0, ent_seen} + (TIME_BITS+1)'(window);
  assign live      = eval_en_q && eval_vld_q && ({1'b0, now_q} < expiry);
  assign expire    = eval_en_q && eval_vld_q && !live;
  assign rank_hit  = live && (own_addr_q != PEER_W'(eval_idx_q)) && (ent_clock > ent_seen);

  // response register loads once the last entry is counted
  assign rsp_load = (state_q == ST_FINISH) && !eval_en_q && (!rsp_valid_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_SWEEP;
          idx_d   = '0;
        end
      end
      ST_SWEEP: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end
      ST_FINISH: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      eval_en_q  <= 1'b0;
      eval_vld_q <= 1'b0;
      eval_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      eval_en_q  <= rd_en;
      eval_vld_q <= valid_q[idx_q];
      eval_idx_q <= idx_q;
    end
  end

  // local time of the request in flight
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      now_q <= req_i.data.local_time;
    end
  end

  // entry presence: set on a nonzero clock write, cleared on a zero clock write or on expiry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_fire && addr_ok) begin
      valid_q[wr_addr] <= (req_i.data.peer_clock != '0);
    end else if (expire) begin
      valid_q[eval_idx_q] <= 1'b0;
    end
  end

  // sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_cnt_q <= '0;
      rank_cnt_q  <= '0;
    end else if (req_fire) begin
      alive_cnt_q <= '0;
      rank_cnt_q  <= '0;
    end else begin
      if (live) begin
        alive_cnt_q <= alive_cnt_q + COUNT_W'(1);
      end
      if (rank_hit) begin
        rank_cnt_q <= rank_cnt_q + COUNT_W'(1);
      end
    end
  end

  // last reported status and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_rank_q  <= RANK_RST;
      cur_alive_q <= ALIVE_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        cur_rank_q  <= rank_cnt_q;
        cur_alive_q <= alive_cnt_q;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q.own_rank       <= rank_cnt_q;
      rsp_q.alive_count    <= alive_cnt_q;
      rsp_q.status_changed <= (rank_cnt_q != cur_rank_q) || (alive_cnt_q != cur_alive_q);
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDRESS_RST;
      ping_q     <= PING_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ADDRESS: own_addr_q <= cfg_data_i[PEER_W-1:0];
        CFG_PING_PERIOD: ping_q     <= cfg_data_i[PING_W-1:0];
        default: ;
      endcase
    end
  end

  // checks

  // a request starts a sweep at the first entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == ST_SWEEP) && (idx_q == '0))
    else $error("sweep did not start after request");

  // evaluation only happens inside a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_en_q |-> (state_q == ST_SWEEP) || (state_q == ST_FINISH))
    else $error("entry evaluated outside a sweep");

  // an expired entry is gone afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |=> !valid_q[$past(eval_idx_q)])
    else $error("expired entry still present");

  // rank counts a subset of the live entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.own_rank <= rsp_q.alive_count))
    else $error("rank exceeds alive count");

endmodule

`default_nettype wire

>>> tb/plrt_status_checker.sv
// plrt_status_checker: watches the request, response and register ports of the peer table
// keeps its own copy of the table, predicts each status response and compares it field by field
// depends on plrt_pkg and plrt_if
`default_nettype none

module plrt_status_checker
  import plrt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  plrt_req_if                        req_mon,
  plrt_rsp_if                        rsp_mon,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         mismatch_count_o,
  output int                         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  // shadow table and status registers
  logic [TIME_BITS-1:0] clock_tab [NUM_PEERS];
  logic [TIME_BITS-1:0] seen_tab  [NUM_PEERS];
  logic [COUNT_W-1:0]   prev_rank;
  logic [COUNT_W-1:0]   prev_alive;
  logic [PEER_W-1:0]    own_addr_q;
  logic [PING_W-1:0]    ping_q;
  plrt_rsp_t            expected_status [$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  // one line per mismatch, printing stops after a while but counting goes on
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count_o < PRINT_CAP) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count_o++;
  endtask

  // write the reporting entry, sweep the whole table, return the new status
  function automatic plrt_rsp_t sweep_table(input plrt_req_t r);
    logic [WINDOW_W-1:0]  window;
    logic [TIME_BITS:0]   deadline;
    int unsigned          live;
    int unsigned          rank;
    plrt_rsp_t            s;
    window = {ping_q, 1'b0};
    if (r.peer_address < NUM_PEERS) begin
      clock_tab[r.peer_address] = r.peer_clock;
      seen_tab[r.peer_address]  = r.local_time;
    end
    live = 0;
    rank = 0;
    for (int k = 0; k < NUM_PEERS; k++) begin
      if (clock_tab[k] != '0) begin
        // expiry sum is one bit wider than the time base, so it never wraps
        deadline = {1'b0, seen_tab[k]} + (TIME_BITS + 1)'(window);
        if ({1'b0, r.local_time} < deadline) begin
          live++;
          if (k != int'(own_addr_q) && clock_tab[k] > seen_tab[k]) rank++;
        end else begin
          clock_tab[k] = '0;
          seen_tab[k]  = '0;
        end
      end
    end
    s.own_rank       = COUNT_W'(rank);
    s.alive_count    = COUNT_W'(live);
    s.status_changed = (s.own_rank != prev_rank) || (s.alive_count != prev_alive);
    prev_rank  = s.own_rank;
    prev_alive = s.alive_count;
    return s;
  endfunction

  // monitor: register writes, responses against the oldest prediction, new requests
  always @(posedge clk_i or negedge rst_ni) begin
    plrt_rsp_t want;
    plrt_rsp_t got;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PEERS; k++) begin
        clock_tab[k] = '0;
        seen_tab[k]  = '0;
      end
      prev_rank  = RANK_RST;
      prev_alive = ALIVE_RST;
      own_addr_q = OWN_ADDRESS_RST;
      ping_q     = PING_PERIOD_RST;
      expected_status.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_ADDRESS: own_addr_q = cfg_data_i[PEER_W-1:0];
          CFG_PING_PERIOD: ping_q     = cfg_data_i[PING_W-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected response, rank", got.own_rank, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.own_rank !== want.own_rank)
            report_mismatch("own_rank", got.own_rank, want.own_rank);
          if (got.alive_count !== want.alive_count)
            report_mismatch("alive_count", got.alive_count, want.alive_count);
          if (got.status_changed !== want.status_changed)
            report_mismatch("status_changed", got.status_changed, want.status_changed);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_status.push_back(sweep_table(req_mon.data));
      end
      outstanding_o <= expected_status.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_peer_liveness_rank_table_core.sv
// tb_peer_liveness_rank_table_core: stimulus, handshake idling and verdict for the peer table
// depends on plrt_pkg, plrt_if, peer_liveness_rank_table_core and plrt_status_checker
`default_nettype none

module tb_peer_liveness_rank_table_core
  import plrt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   STALL_LIMIT  = 20000;
  localparam int                   HOLD_CYCLES  = 1500;
  localparam int                   DRAIN_CYCLES = 300;
  localparam int                   MAX_GAP      = 18;
  localparam int                   POOL_SIZE    = 6;
  localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;
  localparam logic [PEER_W-1:0]    IGNORED_PEER = 8'hff;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    idle_cycles = 0;
  int                    req_mode    = 0;
  int                    rsp_mode    = 1;
  bit                    hold_go     = 1'b0;
  logic                  hold_on     = 1'b0;

  plrt_req_if req_if ();
  plrt_rsp_if rsp_if ();

  peer_liveness_rank_table_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  plrt_status_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any accepted request or response
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_peer_liveness_rank_table_core NOT OK");
      $finish;
    end
  end

  // idle gap per item: none, uniform, or mostly none with long bursts
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(10, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // long hold-off on the response side, once, while requests keep coming
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // response side: random stalls before each response
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    gap = draw_gap(rsp_mode);
    forever begin
      if (gap > 0 || hold_on) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_on) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      if ($urandom_range(0, 39) == 0) rsp_mode = $urandom_range(0, 2);
      gap = draw_gap(rsp_mode);
    end
  end

  // offer one request after a random gap and wait for it to be taken
  task automatic send_req(input logic [PEER_W-1:0] addr, input logic [TIME_BITS-1:0] peer_clk,
                          input logic [TIME_BITS-1:0] now);
    int        gap;
    plrt_req_t r;
    r.peer_address = addr;
    r.peer_clock   = peer_clk;
    r.local_time   = now;
    gap = draw_gap(req_mode);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    if ($urandom_range(0, 39) == 0) req_mode = $urandom_range(0, 2);
  endtask

  // stop offering and wait until every response has come back
  task automatic drain_pending();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // both registers, own address first; upper data bits of the address write are don't-care
  task automatic load_config(input logic [PEER_W-1:0] own, input logic [PING_W-1:0] ping);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_OWN_ADDRESS;
    cfg_data <= {8'($urandom), own};
    @(posedge clk);
    cfg_idx  <= CFG_PING_PERIOD;
    cfg_data <= ping;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // peer traffic: a small pool of peers pinging around a moving local clock,
  // with ignored addresses, stray entries and time jumps mixed in;
  // fill mode walks every address to load the whole table
  task automatic run_traffic(input int unsigned count, input logic [PEER_W-1:0] own,
                             input logic [PING_W-1:0] ping, input bit fill);
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] peer_clk;
    logic [PEER_W-1:0]    addr;
    logic [PEER_W-1:0]    pool [POOL_SIZE];
    int unsigned          window;
    int unsigned          done;
    int unsigned          pick;
    int unsigned          start;
    longint               skew;
    window = 2 * ping;
    case ($urandom_range(0, 2))
      0:       now_ms = TIME_BITS'($urandom_range(0, 100000));
      1:       now_ms = rand_time();
      default: now_ms = TIME_MAX - TIME_BITS'($urandom_range(0, 4 * window + 10));
    endcase
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = PEER_W'($urandom_range(0, NUM_PEERS - 1));
    if (own < NUM_PEERS) pool[0] = own;
    start = $urandom_range(0, NUM_PEERS - 1);
    done  = 0;
    while (done < count) begin
      pick = fill ? 99 : $urandom_range(0, 99);
      if (pick < 8) begin
        // ignored address, does not count
        addr     = IGNORED_PEER;
        peer_clk = rand_time();
      end else if (pick < 16) begin
        addr     = PEER_W'($urandom_range(0, NUM_PEERS - 1));
        peer_clk = rand_time();
        if ($urandom_range(0, 3) == 0) now_ms = rand_time();
        done++;
      end else begin
        if (fill) begin
          addr     = PEER_W'((start + done) % NUM_PEERS);
          now_ms   = now_ms + TIME_BITS'($urandom_range(0, 1));
          peer_clk = now_ms + TIME_BITS'($urandom_range(1, 1000));
        end else begin
          addr = pool[$urandom_range(0, POOL_SIZE - 1)];
          if ($urandom_range(0, 19) == 0) begin
            now_ms = now_ms + TIME_BITS'($urandom_range(0, 2 * window + 2));
          end else begin
            now_ms = now_ms + TIME_BITS'($urandom_range(0, window / 4 + 1));
          end
          skew     = longint'($urandom_range(0, 2 * window + 2)) - longint'(window + 1);
          peer_clk = ($urandom_range(0, 15) == 0) ? '0 : now_ms + TIME_BITS'(skew);
        end
        done++;
      end
      send_req(addr, peer_clk, now_ms);
    end
  endtask

  // main sequence
  initial begin
    logic [PEER_W-1:0] own;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_OWN_ADDRESS;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: own address 0, expiry after 20000 ms
    send_req(8'd0,   TIME_MAX,       48'd0);
    send_req(8'd1,   48'd1,          48'd0);
    send_req(8'd254, 48'd100,        48'd1000);
    send_req(IGNORED_PEER, TIME_MAX, 48'd1000);
    send_req(8'd2,   48'd0,          48'd1000);
    send_req(8'd3,   48'd5000,       48'd5000);
    // last local time before and first local time of expiry for entries seen at 0
    send_req(IGNORED_PEER, 48'd0,    48'd19999);
    send_req(IGNORED_PEER, 48'd0,    48'd20000);
    // top of the time range, expiry sum past the time width
    send_req(8'd10,  TIME_MAX,       TIME_MAX - 1);
    send_req(8'd11,  TIME_MAX - 1,   TIME_MAX);
    send_req(IGNORED_PEER, 48'd0,    TIME_MAX);
    // local time going backwards
    send_req(8'd0,   48'd0,          48'd0);
    send_req(8'd128, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    send_req(8'd127, 48'hAAAA_AAAA_AAAB, 48'hAAAA_AAAA_AAAA);
    drain_pending();

    // own address outside the table, longest period
    load_config(8'd255, 16'hffff);
    send_req(8'd0, 48'd10, 48'd5);
    send_req(8'd5, 48'd10, 48'd5);
    drain_pending();

    // zero period: everything expires on the spot
    load_config(8'd7, 16'd0);
    send_req(8'd7, 48'd9, 48'd3);
    send_req(IGNORED_PEER, 48'd0, 48'd3);
    drain_pending();

    // shortest period, own address at the top of the table
    load_config(8'd254, 16'd1);
    send_req(8'd254, 48'd9, 48'd3);
    send_req(8'd1,   48'd9, 48'd4);
    send_req(IGNORED_PEER, 48'd0, 48'd5);
    drain_pending();

    // random traffic over several register settings
    own = PEER_W'($urandom_range(0, NUM_PEERS - 1));
    load_config(own, 16'd10000);
    hold_go = 1'b1;
    run_traffic(160, own, 16'd10000, 1'b0);
    drain_pending();

    load_config(8'd0, 16'd1);
    run_traffic(160, 8'd0, 16'd1, 1'b0);
    drain_pending();

    load_config(8'd254, 16'hffff);
    run_traffic(160, 8'd254, 16'hffff, 1'b0);
    drain_pending();

    // whole table alive, rank reaching every live entry
    load_config(8'd255, 16'hffff);
    run_traffic(300, 8'd255, 16'hffff, 1'b1);
    drain_pending();

    for (int p = 0; p < 3; p++) begin
      logic [PING_W-1:0] ping;
      own  = PEER_W'($urandom_range(0, NUM_PEERS - 1));
      ping = (p == 1) ? 16'($urandom_range(1, 100)) : 16'($urandom_range(1, 65535));
      load_config(own, ping);
      run_traffic(160, own, ping, 1'b0);
      drain_pending();
    end

    own = PEER_W'($urandom_range(0, NUM_PEERS - 1));
    load_config(own, 16'd2);
    run_traffic(160, own, 16'd2, 1'b0);
    drain_pending();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_peer_liveness_rank_table_core OK");
    end else begin
      $display("tb_peer_liveness_rank_table_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> peer_liveness_rank_table_core.f
rtl/plrt_pkg.sv
rtl/plrt_if.sv
rtl/plrt_ram.sv
rtl/peer_liveness_rank_table_core.sv
tb/plrt_status_checker.sv
tb/tb_peer_liveness_rank_table_core.sv
